>>> hw/rtl/bsrf_pkg.sv
// ----------------------------------------------------------------------------
// bsrf_pkg
// shared types, constants and helpers of the bitmap rank/find store
// ----------------------------------------------------------------------------
package bsrf_pkg;

    localparam int WORD_BITS_C      = 64;
    localparam int DEF_WORD_COUNT   = 64;
    localparam int IDX_W            = 13;
    localparam int FW_W             = 7;
    localparam int WADDR_W          = IDX_W - 6;
    localparam int APB_AW           = 3;
    localparam logic [APB_AW-1:0] ADDR_LENGTH = 3'd0;
    localparam logic [IDX_W-1:0]  LENGTH_RESET = 13'd4096;

    typedef enum logic [2:0] {
        KIND_SET     = 3'd0,
        KIND_CLEAR   = 3'd1,
        KIND_TEST    = 3'd2,
        KIND_FIND    = 3'd3,
        KIND_COUNT   = 3'd4,
        KIND_EXTRACT = 3'd5,
        KIND_INSERT  = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               ok;
        logic [IDX_W-1:0]   idx;
        logic [WADDR_W-1:0] w0;
        logic [5:0]         off;
        logic [63:0]        v_al;
        logic [63:0]        m_al;
    } cmd_t;

    typedef struct packed {
        logic             active;
        logic             found;
        logic [63:0]      acc;
    } tok_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] len;
    } trunc_t;

    // bits of a word whose global position lies below base + d
    function automatic logic [63:0] top_mask(input int d);
        logic [63:0] m;
        if (d <= 0)
            m = '0;
        else if (d >= 64)
            m = '1;
        else
            m = ~(64'hFFFF_FFFF_FFFF_FFFF >> d);
        return m;
    endfunction

    // position of the first set bit counted from the msb
    function automatic logic [5:0] lead_pos(input logic [63:0] w);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (w[i])
                p = 6'(63 - i);
        end
        return p;
    endfunction

endpackage

>>> hw/rtl/bsrf_cell.sv
// ----------------------------------------------------------------------------
// bsrf_cell
// one 64-bit word of the store; acts on the token as it passes
// ----------------------------------------------------------------------------
module bsrf_cell
    import bsrf_pkg::*;
#(
    parameter int CELL_ID = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   cmd,
    input  trunc_t trunc,
    input  tok_t   tok_in,
    output tok_t   tok_out
);

    localparam int BASE = CELL_ID * WORD_BITS_C;

    logic [63:0] word_reg, word_next;
    tok_t        tok_reg, tok_next;
    logic        hit0, hit1;
    logic [63:0] bitm, low_bits, up_bits;
    logic [6:0]  roff;
    int          d;

    assign d        = int'(cmd.idx) - BASE;
    assign hit0     = (CELL_ID == int'(cmd.w0));
    assign hit1     = (CELL_ID == int'(cmd.w0) + 1) && (cmd.off != '0);
    assign bitm     = 64'h8000_0000_0000_0000 >> cmd.off;
    assign up_bits  = word_reg & top_mask(d);
    assign low_bits = word_reg & ~top_mask(d);
    assign roff     = 7'd64 - {1'b0, cmd.off};

    always_comb
    begin
        word_next = word_reg;
        tok_next  = tok_in;
        if (trunc.we)
            word_next = word_reg & top_mask(int'(trunc.len) - BASE);
        else if (tok_in.active && cmd.ok)
        begin
            case (cmd.kind)
                KIND_SET:
                    if (hit0) word_next = word_reg | bitm;
                KIND_CLEAR:
                    if (hit0) word_next = word_reg & ~bitm;
                KIND_TEST:
                    if (hit0) tok_next.acc = {63'd0, |(word_reg & bitm)};
                KIND_FIND:
                    if (!tok_in.found && low_bits != '0)
                    begin
                        tok_next.found = 1'b1;
                        tok_next.acc   = 64'(BASE) + 64'(lead_pos(low_bits));
                    end
                KIND_COUNT:
                    tok_next.acc = tok_in.acc + 64'($countones(up_bits));
                KIND_EXTRACT:
                    if (hit0)
                        tok_next.acc = word_reg << cmd.off;
                    else if (hit1)
                        tok_next.acc = tok_in.acc | (word_reg >> roff);
                KIND_INSERT:
                    if (hit0)
                        word_next = (word_reg & ~(cmd.m_al >> cmd.off))
                                  | (cmd.v_al >> cmd.off);
                    else if (hit1)
                        word_next = (word_reg & ~(cmd.m_al << roff))
                                  | (cmd.v_al << roff);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            word_reg <= word_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> hw/rtl/bitmap_store_rank_find_field_core.sv
// ----------------------------------------------------------------------------
// bitmap_store_rank_find_field_core
// bit vector store with set/clear/test, find next set, rank and field access
//
//   port group   | dir  | handshake
//   ------------ | ---- | ---------------------------------------
//   input word   | in   | in_valid / in_ready
//   result word  | out  | out_valid / out_ready
//   config       | in   | apb psel/penable, pready tied high
//
// every word runs from accept to a valid result through a start register, then a
// token walks the chain of word cells, each cell registering it, then two registers.
// the next word is accepted only once the token has left the chain and the two
// output registers are not both full.
// reset clears all words and sets the length to 4096; no clearing pass.
// a stalled output holds one finished result plus one result in the output register.
// ----------------------------------------------------------------------------
module bitmap_store_rank_find_field_core
    import bsrf_pkg::*;
#(
    parameter int WORD_COUNT = DEF_WORD_COUNT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         kind,
    input  logic [IDX_W-1:0]   bit_index,
    input  logic [FW_W-1:0]    field_width,
    input  logic [63:0]        field_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [63:0]        answer,
    output logic               range_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CAP = WORD_COUNT * WORD_BITS_C;

    logic [IDX_W-1:0] length_reg, length_next;
    logic [IDX_W-1:0] eff_len, new_eff, elen_reg;
    cmd_t             cmd_reg;
    logic [FW_W-1:0]  fw_reg;
    logic             start_reg, busy_reg, fin_valid_reg, out_valid_reg;
    logic [63:0]      fin_ans_reg, fin_ans_next, out_ans_reg;
    logic             fin_err_reg, out_err_reg;
    logic             accept, cfg_we, ok;
    logic [IDX_W:0]   fend;
    logic [6:0]       sh;
    trunc_t           trunc;
    tok_t             tok [WORD_COUNT+1];
    tok_t             tok_first;

    assign pready      = 1'b1;
    assign prdata      = {19'd0, length_reg};
    assign cfg_we      = psel && penable && pwrite && (paddr == ADDR_LENGTH);
    assign length_next = pwdata[IDX_W-1:0];
    assign eff_len     = (32'(length_reg) < CAP) ? length_reg : IDX_W'(CAP);
    assign new_eff     = (32'(length_next) < CAP) ? length_next : IDX_W'(CAP);
    assign trunc       = '{we: cfg_we, len: new_eff};

    assign in_ready = !busy_reg && !(fin_valid_reg && out_valid_reg);
    assign accept   = in_valid && in_ready;
    assign fend     = {1'b0, bit_index} + (IDX_W+1)'(field_width);
    assign sh       = 7'd64 - field_width;

    always_comb
    begin
        case (kind)
            KIND_SET, KIND_CLEAR, KIND_TEST:
                ok = bit_index < eff_len;
            KIND_FIND, KIND_COUNT:
                ok = bit_index <= eff_len;
            KIND_EXTRACT, KIND_INSERT:
                ok = (field_width != '0) && (field_width <= 7'd64)
                     && (fend <= {1'b0, eff_len});
            default:
                ok = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= LENGTH_RESET;
        else if (cfg_we)
            length_reg <= length_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.kind <= kind_t'(kind);
            cmd_reg.ok   <= ok;
            cmd_reg.idx  <= bit_index;
            cmd_reg.w0   <= bit_index[IDX_W-1:6];
            cmd_reg.off  <= bit_index[5:0];
            cmd_reg.v_al <= field_value << sh;
            cmd_reg.m_al <= 64'hFFFF_FFFF_FFFF_FFFF << sh;
            fw_reg       <= field_width;
            elen_reg     <= eff_len;
        end
    end

    assign tok_first = '{active: start_reg, found: 1'b0, acc: 64'd0};
    assign tok[0]    = tok_first;

    for (genvar g = 0; g < WORD_COUNT; g++)
    begin : g_cell
        bsrf_cell #(.CELL_ID(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd_reg),
            .trunc   (trunc),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    always_comb
    begin
        fin_ans_next = '0;
        if (!cmd_reg.ok)
        begin
            if (cmd_reg.kind == KIND_FIND)
                fin_ans_next = 64'(elen_reg);
        end
        else
        begin
            case (cmd_reg.kind)
                KIND_TEST, KIND_COUNT:
                    fin_ans_next = tok[WORD_COUNT].acc;
                KIND_FIND:
                    fin_ans_next = tok[WORD_COUNT].found ? tok[WORD_COUNT].acc
                                                         : 64'(elen_reg);
                KIND_EXTRACT:
                    fin_ans_next = tok[WORD_COUNT].acc >> (7'd64 - fw_reg);
                default:
                    fin_ans_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept;
            if (accept)
                busy_reg <= 1'b1;
            else if (tok[WORD_COUNT].active)
                busy_reg <= 1'b0;
            if (tok[WORD_COUNT].active)
                fin_valid_reg <= 1'b1;
            else if (fin_valid_reg && (!out_valid_reg || out_ready))
                fin_valid_reg <= 1'b0;
            if (fin_valid_reg && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok[WORD_COUNT].active)
        begin
            fin_ans_reg <= fin_ans_next;
            fin_err_reg <= !cmd_reg.ok;
        end
        if (fin_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_ans_reg <= fin_ans_reg;
            out_err_reg <= fin_err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign answer      = out_ans_reg;
    assign range_error = out_err_reg;

    a_start_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> start_reg)
        else $error("token not launched after accept");

    a_token_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok[WORD_COUNT].active |-> busy_reg)
        else $error("token left chain while idle");

    a_single_start: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |=> !start_reg)
        else $error("two tokens launched back to back");

    a_no_finish_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        tok[WORD_COUNT].active |-> !fin_valid_reg)
        else $error("finished result overwritten");

endmodule

>>> tb/tb_bitmap_store_rank_find_field_core.sv
// ----------------------------------------------------------------------------
// tb_bitmap_store_rank_find_field_core
// drives directed and random operations through the bitmap store, predicts
// every result with a local bit model and checks the results in order, across
// several length settings and idling phases
// ----------------------------------------------------------------------------
module tb_bitmap_store_rank_find_field_core;
    import bsrf_pkg::*;

    localparam int CAP        = 4096;
    localparam int LATENCY    = 70;
    localparam int CYCLE_CAP  = 1500000;

    typedef struct packed {
        kind_t       kind;
        logic [12:0] idx;
        logic [6:0]  fw;
        logic [63:0] val;
    } op_t;

    typedef struct packed {
        logic [63:0] answer;
        logic        err;
    } res_t;

    typedef struct packed {
        op_t         op;
        logic        known;
        res_t        res;
        logic [12:0] len;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] kind = '0;
    logic [12:0] bit_index = '0;
    logic [6:0] field_width = '0;
    logic [63:0] field_value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [63:0] answer;
    logic range_error;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    logic [0:CAP-1] bits_q;
    logic [12:0] length_q;
    res_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;

    bitmap_store_rank_find_field_core uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [12:0] eff_len();
        return (length_q > CAP) ? 13'(CAP) : length_q;
    endfunction

    function automatic res_t predict_op(input op_t op);
        res_t r;
        int len;
        int i;
        len = eff_len();
        r = '0;
        case (op.kind)
            KIND_SET, KIND_CLEAR, KIND_TEST:
            begin
                if (op.idx >= len)
                    r.err = 1'b1;
                else if (op.kind == KIND_SET)
                    bits_q[op.idx] = 1'b1;
                else if (op.kind == KIND_CLEAR)
                    bits_q[op.idx] = 1'b0;
                else
                    r.answer = 64'(bits_q[op.idx]);
            end
            KIND_FIND:
            begin
                r.answer = 64'(len);
                if (op.idx > len)
                    r.err = 1'b1;
                else
                    for (i = op.idx; i < len; i++)
                        if (bits_q[i])
                        begin
                            r.answer = 64'(i);
                            break;
                        end
            end
            KIND_COUNT:
            begin
                if (op.idx > len)
                    r.err = 1'b1;
                else
                    for (i = 0; i < op.idx; i++)
                        r.answer += 64'(bits_q[i]);
            end
            KIND_EXTRACT, KIND_INSERT:
            begin
                if (op.fw == 0 || op.fw > 64 || int'(op.idx) + int'(op.fw) > len)
                    r.err = 1'b1;
                else if (op.kind == KIND_EXTRACT)
                    for (i = 0; i < op.fw; i++)
                        r.answer = {r.answer[62:0], bits_q[op.idx + i]};
                else
                    for (i = 0; i < op.fw; i++)
                        bits_q[op.idx + i] = op.val[op.fw - 1 - i];
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // result side
    always @(posedge clk)
    begin
        res_t exp_r;
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation");
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (answer !== exp_r.answer)
                begin
                    $error("answer exp %h got %h", exp_r.answer, answer);
                    errors++;
                end
                if (range_error !== exp_r.err)
                begin
                    $error("range_error exp %0d got %0d", exp_r.err, range_error);
                    errors++;
                end
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send_op(input op_t op, input logic known, input res_t exp_r);
        res_t p;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        kind <= op.kind;
        bit_index <= op.idx;
        field_width <= op.fw;
        field_value <= op.val;
        do
            @(posedge clk);
        while (!in_ready);
        p = predict_op(op);
        if (known && p.answer !== exp_r.answer)
        begin
            $error("row answer exp %h got %h", exp_r.answer, p.answer);
            errors++;
        end
        if (known && p.err !== exp_r.err)
        begin
            $error("row range_error exp %0d got %0d", exp_r.err, p.err);
            errors++;
        end
        pending_results.push_back(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_length(input logic [12:0] len);
        int i;
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_LENGTH;
        pwdata <= 32'(len);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        length_q = len;
        for (i = eff_len(); i < CAP; i++)
            bits_q[i] = 1'b0;
    endtask

    function automatic op_t rand_op(input int len);
        op_t op;
        int lim;
        op.kind = kind_t'($urandom_range(6));
        lim = (len > 0) ? len - 1 : 0;
        if ($urandom_range(9) == 0)
            op.idx = 13'($urandom);
        else if (op.kind inside {KIND_FIND, KIND_COUNT} && $urandom_range(3) == 0)
            op.idx = 13'($urandom_range(lim + 1));
        else
            op.idx = 13'($urandom_range(lim));
        op.fw = ($urandom_range(15) == 0) ? 7'($urandom) : 7'($urandom_range(64, 1));
        if (op.kind == KIND_EXTRACT || op.kind == KIND_INSERT)
            if ($urandom_range(7) != 0 && len >= op.fw && op.fw >= 1 && op.fw <= 64)
                op.idx = 13'($urandom_range(len - op.fw));
        op.val = {$urandom, $urandom};
        if ($urandom_range(20) == 0)
            op.kind = kind_t'(3'd7);
        return op;
    endfunction

    row_t dir_rows[] = '{
        '{'{KIND_TEST, 13'd0, 7'd1, 64'd0}, 1'b1, '{64'd0, 1'b0}, 13'd4096},
        '{'{KIND_FIND, 13'd0, 7'd1, 64'd0}, 1'b1, '{64'd4096, 1'b0}, 13'd4096},
        '{'{KIND_COUNT, 13'd4096, 7'd1, 64'd0}, 1'b1, '{64'd0, 1'b0}, 13'd4096},
        '{'{KIND_SET, 13'd4096, 7'd1, 64'd0}, 1'b1, '{64'd0, 1'b1}, 13'd4096},
        '{'{KIND_FIND, 13'd8191, 7'd1, 64'd0}, 1'b1, '{64'd4096, 1'b1}, 13'd4096},
        '{'{KIND_COUNT, 13'd4097, 7'd1, 64'd0}, 1'b1, '{64'd0, 1'b1}, 13'd4096},
        '{'{KIND_EXTRACT, 13'd0, 7'd0, 64'd0}, 1'b1, '{64'd0, 1'b1}, 13'd4096},
        '{'{KIND_INSERT, 13'd0, 7'd65, 64'd0}, 1'b1, '{64'd0, 1'b1}, 13'd4096},
        '{'{KIND_INSERT, 13'd4033, 7'd64, 64'd0}, 1'b1, '{64'd0, 1'b1}, 13'd4096},
        '{'{kind_t'(3'd7), 13'd5, 7'd5, 64'd5}, 1'b1, '{64'd0, 1'b0}, 13'd4096},
        '{'{KIND_SET, 13'd0, 7'd1, 64'd0}, 1'b0, '0, 13'd4096},
        '{'{KIND_SET, 13'd4095, 7'd1, 64'd0}, 1'b0, '0, 13'd4096},
        '{'{KIND_FIND, 13'd1, 7'd1, 64'd0}, 1'b1, '{64'd4095, 1'b0}, 13'd4096},
        '{'{KIND_INSERT, 13'd60, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, '0, 13'd4096},
        '{'{KIND_EXTRACT, 13'd56, 7'd64, 64'd0}, 1'b0, '0, 13'd4096},
        '{'{KIND_INSERT, 13'd4032, 7'd64, 64'hA5A5_0F0F_FFFF_0001}, 1'b0, '0, 13'd4096},
        '{'{KIND_INSERT, 13'd130, 7'd3, 64'hFFFF_FFFF_FFFF_FFF5}, 1'b0, '0, 13'd4096},
        '{'{KIND_EXTRACT, 13'd129, 7'd5, 64'd0}, 1'b0, '0, 13'd4096},
        '{'{KIND_COUNT, 13'd4096, 7'd1, 64'd0}, 1'b0, '0, 13'd4096},
        '{'{KIND_CLEAR, 13'd0, 7'd1, 64'd0}, 1'b0, '0, 13'd4096},
        '{'{KIND_TEST, 13'd0, 7'd1, 64'd0}, 1'b1, '{64'd0, 1'b0}, 13'd4096},
        '{'{KIND_FIND, 13'd4093, 7'd1, 64'd0}, 1'b0, '0, 13'd4096},
        '{'{KIND_TEST, 13'd99, 7'd1, 64'd0}, 1'b1, '{64'd0, 1'b1}, 13'd70},
        '{'{KIND_EXTRACT, 13'd0, 7'd64, 64'd0}, 1'b0, '0, 13'd70},
        '{'{KIND_FIND, 13'd0, 7'd1, 64'd0}, 1'b1, '{64'd0, 1'b0}, 13'd0}
    };

    initial
    begin
        int lens[6];
        int idle_s[4];
        int idle_r[4];
        int n;
        int ph;
        bits_q = '0;
        length_q = LENGTH_RESET;
        lens = '{4096, 0, 1, 8191, 100, 4095};
        idle_s = '{0, 77, 0, 20};
        idle_r = '{0, 0, 77, 20};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].len != length_q)
                write_length(dir_rows[i].len);
            send_op(dir_rows[i].op, dir_rows[i].known, dir_rows[i].res);
        end
        hold_off = 300;
        for (n = 0; n < 6; n++)
            send_op(rand_op(eff_len()), 1'b0, '0);
        drain();
        for (ph = 0; ph < 12; ph++)
        begin
            write_length(13'(lens[ph % 6]));
            send_idle = idle_s[ph % 4];
            recv_stall = idle_r[ph % 4];
            for (n = 0; n < 150; n++)
                send_op(rand_op(eff_len()), 1'b0, '0);
        end
        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
